// ===== rtl/source_byte_tokenizer_defines.svh =====
// assertion macros for the source byte tokenizer
`ifndef SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_DEFINES_SVH
`ifndef SYNTH
`define SBT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SBT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SBT_ASSERT(label, clk, rst, prop)
`define SBT_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/sbt_pkg.sv =====
// types and constants shared by the tokenizer modules
`timescale 1ns / 1ps
package sbt_pkg;
  typedef struct packed {
    logic [7:0] ch;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        run_last;
  } out_item_t;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_IDENT = 6'd1;
  localparam logic [5:0] K_INT = 6'd2;
  localparam logic [5:0] K_STRING = 6'd3;
  localparam logic [5:0] K_BOOL = 6'd4;
  localparam logic [5:0] K_UNKNOWN = 6'd40;

  // keyword kinds
  localparam logic [5:0] K_KW_INT = 6'd5, K_KW_BOOL = 6'd6, K_KW_STRING = 6'd7,
    K_KW_FUNC = 6'd8, K_KW_FOR = 6'd9, K_KW_TO = 6'd10, K_KW_WHILE = 6'd11,
    K_KW_IF = 6'd12, K_KW_ELSE = 6'd13, K_KW_RETURN = 6'd14, K_KW_PRINT = 6'd15,
    K_KW_INPUT = 6'd16, K_KW_NEWLINE = 6'd17, K_KW_PATTERN = 6'd18;

  // operator kinds
  localparam logic [5:0] K_PLUS = 6'd19, K_MINUS = 6'd20, K_STAR = 6'd21,
    K_SLASH = 6'd22, K_PCT = 6'd23, K_ASSIGN = 6'd24, K_EQ = 6'd25, K_NOT = 6'd26,
    K_NE = 6'd27, K_LT = 6'd28, K_LE = 6'd29, K_GT = 6'd30, K_GE = 6'd31,
    K_ANDAND = 6'd32, K_OROR = 6'd33, K_LPAREN = 6'd34, K_RPAREN = 6'd35,
    K_LBRACE = 6'd36, K_RBRACE = 6'd37, K_COMMA = 6'd38, K_SEMI = 6'd39;

  // up to three tokens per byte travel together to the back part
  typedef struct packed {
    logic [1:0]  count;
    out_item_t   t0;
    out_item_t   t1;
    out_item_t   t2;
  } bundle_t;

  function automatic logic [5:0] word_kind(input logic [55:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    unique case (n)
      3'd2: begin
        if (w[15:0] == 16'h6f74) k = K_KW_TO;
        else if (w[15:0] == 16'h6669) k = K_KW_IF;
      end
      3'd3: begin
        if (w[23:0] == 24'h746e69) k = K_KW_INT;
        else if (w[23:0] == 24'h726f66) k = K_KW_FOR;
      end
      3'd4: begin
        if (w[31:0] == 32'h6c6f6f62) k = K_KW_BOOL;
        else if (w[31:0] == 32'h636e7566) k = K_KW_FUNC;
        else if (w[31:0] == 32'h65736c65) k = K_KW_ELSE;
        else if (w[31:0] == 32'h65757274) k = K_BOOL;
      end
      3'd5: begin
        if (w[39:0] == 40'h656c696877) k = K_KW_WHILE;
        else if (w[39:0] == 40'h746e697270) k = K_KW_PRINT;
        else if (w[39:0] == 40'h7475706e69) k = K_KW_INPUT;
        else if (w[39:0] == 40'h65736c6166) k = K_BOOL;
      end
      3'd6: begin
        if (w[47:0] == 48'h676e69727473) k = K_KW_STRING;
        else if (w[47:0] == 48'h6e7275746572) k = K_KW_RETURN;
      end
      3'd7: begin
        if (w == 56'h656e696c77656e) k = K_KW_NEWLINE;
        else if (w == 56'h6e726574746170) k = K_KW_PATTERN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction
endpackage

// ===== rtl/sbt_front.sv =====
// front part: scanner state, classification and token formation
`timescale 1ns / 1ps
module sbt_front #(
  parameter int POSITION_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sbt_pkg::in_item_t in_data,
  output logic             b_valid,
  input  logic             b_ready,
  output sbt_pkg::bundle_t b_data
);
  typedef enum logic [8:0] {
    M_IDLE = 9'b000000001, M_IDENT = 9'b000000010, M_IDLONG = 9'b000000100,
    M_NUMBER = 9'b000001000, M_STRING = 9'b000010000, M_STRESC = 9'b000100000,
    M_LINECOM = 9'b001000000, M_BLOCK = 9'b010000000, M_BLOCKSTAR = 9'b100000000
  } mode_t;
  localparam logic [2:0] OP_SLASH = 3'd1, OP_EQ = 3'd2, OP_BANG = 3'd3, OP_LT = 3'd4,
    OP_GT = 3'd5, OP_AMP = 3'd6, OP_BAR = 3'd7, OP_NONE = 3'd0;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;

  mode_t mode, mode_next;
  logic [2:0] pend, pend_next;
  logic [POSITION_WIDTH-1:0] pos, pos_next, tbeg, tbeg_next;
  logic [LINE_WIDTH-1:0] line, line_next;
  logic [55:0] wbuf, wbuf_next;
  logic [2:0] wlen, wlen_next;
  sbt_pkg::bundle_t bun;

  logic [7:0] c;
  logic alpha, digit, take;
  assign c = in_data.ch;
  assign alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  assign digit = c >= 8'h30 && c <= 8'h39;
  assign in_stall = !b_ready;
  assign take = in_valid && b_ready;

  function automatic logic [5:0] op_single(input logic [2:0] o);
    logic [5:0] k;
    unique case (o)
      OP_SLASH: k = sbt_pkg::K_SLASH;
      OP_EQ: k = sbt_pkg::K_ASSIGN;
      OP_BANG: k = sbt_pkg::K_NOT;
      OP_LT: k = sbt_pkg::K_LT;
      OP_GT: k = sbt_pkg::K_GT;
      default: k = sbt_pkg::K_UNKNOWN;
    endcase
    return k;
  endfunction

  always_comb begin
    logic consumed, lin;
    logic [POSITION_WIDTH-1:0] pinc;
    logic [2:0] op;
    logic [5:0] dk;
    logic [7:0] sec;
    mode_next = mode; pend_next = pend; tbeg_next = tbeg; line_next = line;
    wbuf_next = wbuf; wlen_next = wlen;
    bun = '0;
    consumed = 1'b0; lin = 1'b0; op = OP_NONE; dk = sbt_pkg::K_EOF; sec = 8'd0;
    pinc = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
    pos_next = pinc;
    if (pend != OP_NONE) begin
      pend_next = OP_NONE;
      unique case (pend)
        OP_EQ, OP_BANG, OP_LT, OP_GT: sec = 8'h3d;
        OP_AMP: sec = 8'h26;
        OP_BAR: sec = 8'h7c;
        default: sec = 8'h00;
      endcase
      unique case (pend)
        OP_EQ: dk = sbt_pkg::K_EQ;
        OP_BANG: dk = sbt_pkg::K_NE;
        OP_LT: dk = sbt_pkg::K_LE;
        OP_GT: dk = sbt_pkg::K_GE;
        OP_AMP: dk = sbt_pkg::K_ANDAND;
        default: dk = sbt_pkg::K_OROR;
      endcase
      if (pend == OP_SLASH && c == 8'h2f) begin
        mode_next = M_LINECOM; consumed = 1'b1;
      end else if (pend == OP_SLASH && c == 8'h2a) begin
        mode_next = M_BLOCK; consumed = 1'b1;
      end else if (pend != OP_SLASH && c == sec) begin
        bun.t0.token_kind = dk;
        bun.t0.token_start = 16'(tbeg);
        bun.t0.token_length = 16'd2;
        bun.count = 2'd1; consumed = 1'b1;
      end else begin
        bun.t0.token_kind = op_single(pend);
        bun.t0.token_start = 16'(tbeg);
        bun.t0.token_length = 16'd1;
        bun.count = 2'd1;
      end
    end else begin
      unique case (mode)
        M_IDENT, M_IDLONG: begin
          if (alpha || digit) begin
            consumed = 1'b1;
            if (mode == M_IDENT && wlen < 3'd7) begin
              wbuf_next = wbuf | (56'(c) << {wlen, 3'b000});
              wlen_next = wlen + 3'd1;
            end else mode_next = M_IDLONG;
          end else begin
            bun.t0.token_kind = (mode == M_IDLONG) ? sbt_pkg::K_IDENT
                                                   : sbt_pkg::word_kind(wbuf, wlen);
            bun.t0.token_start = 16'(tbeg);
            bun.t0.token_length = 16'(pos - tbeg);
            bun.count = 2'd1; mode_next = M_IDLE;
          end
        end
        M_NUMBER: begin
          if (digit) consumed = 1'b1;
          else begin
            bun.t0.token_kind = sbt_pkg::K_INT;
            bun.t0.token_start = 16'(tbeg);
            bun.t0.token_length = 16'(pos - tbeg);
            bun.count = 2'd1; mode_next = M_IDLE;
          end
        end
        M_STRING: begin
          consumed = 1'b1;
          if (c == 8'h5c) mode_next = M_STRESC;
          else if (c == 8'h22) begin
            bun.t0.token_kind = sbt_pkg::K_STRING;
            bun.t0.token_start = 16'(tbeg);
            bun.t0.token_length = 16'(pos - tbeg);
            bun.count = 2'd1; mode_next = M_IDLE;
          end
        end
        M_STRESC: begin
          consumed = 1'b1; mode_next = M_STRING;
        end
        M_LINECOM: begin
          if (c == 8'h0a) mode_next = M_IDLE;
          else consumed = 1'b1;
        end
        M_BLOCK: begin
          consumed = 1'b1;
          if (c == 8'h2a) mode_next = M_BLOCKSTAR;
          else if (c == 8'h0a) lin = 1'b1;
        end
        M_BLOCKSTAR: begin
          consumed = 1'b1;
          if (c == 8'h2f) mode_next = M_IDLE;
          else if (c != 8'h2a) begin
            mode_next = M_BLOCK;
            if (c == 8'h0a) lin = 1'b1;
          end
        end
        default: mode_next = M_IDLE;
      endcase
    end
    // line stamp of a token finished by this byte precedes the byte's own newline
    bun.t0.token_line = 16'(line);
    if (!consumed) begin
      bun.t1.token_start = 16'(pos);
      bun.t1.token_length = 16'd1;
      bun.t1.token_line = 16'(line);
      unique case (c)
        8'h20, 8'h09, 8'h0d: ;
        8'h0a: lin = 1'b1;
        8'h22: begin mode_next = M_STRING; tbeg_next = pinc; end
        8'h2f: op = OP_SLASH;
        8'h3d: op = OP_EQ;
        8'h21: op = OP_BANG;
        8'h3c: op = OP_LT;
        8'h3e: op = OP_GT;
        8'h26: op = OP_AMP;
        8'h7c: op = OP_BAR;
        8'h2b: bun.t1.token_kind = sbt_pkg::K_PLUS;
        8'h2d: bun.t1.token_kind = sbt_pkg::K_MINUS;
        8'h2a: bun.t1.token_kind = sbt_pkg::K_STAR;
        8'h25: bun.t1.token_kind = sbt_pkg::K_PCT;
        8'h28: bun.t1.token_kind = sbt_pkg::K_LPAREN;
        8'h29: bun.t1.token_kind = sbt_pkg::K_RPAREN;
        8'h7b: bun.t1.token_kind = sbt_pkg::K_LBRACE;
        8'h7d: bun.t1.token_kind = sbt_pkg::K_RBRACE;
        8'h2c: bun.t1.token_kind = sbt_pkg::K_COMMA;
        8'h3b: bun.t1.token_kind = sbt_pkg::K_SEMI;
        default: begin
          if (alpha) begin
            mode_next = M_IDENT; tbeg_next = pos; wbuf_next = 56'(c); wlen_next = 3'd1;
          end else if (digit) begin
            mode_next = M_NUMBER; tbeg_next = pos;
          end else bun.t1.token_kind = sbt_pkg::K_UNKNOWN;
        end
      endcase
      if (op != OP_NONE) begin
        pend_next = op; tbeg_next = pos;
      end
      if (bun.t1.token_kind != sbt_pkg::K_EOF) begin
        if (bun.count == 2'd0) bun.t0 = bun.t1;
        bun.count = bun.count + 2'd1;
      end
    end
    if (lin && line != LINE_MAX) line_next = line + 1'b1;
    if (in_data.final_byte) begin
      // flush: pending operator or open token, then end of file
      bun.t2 = '0;
      bun.t2.token_line = 16'(line_next);
      bun.t2.token_start = 16'(pinc);
      if (pend_next != OP_NONE) begin
        bun.t2.token_kind = op_single(pend_next);
        bun.t2.token_start = 16'(tbeg_next);
        bun.t2.token_length = 16'd1;
      end else if (mode_next == M_IDENT || mode_next == M_IDLONG) begin
        bun.t2.token_kind = (mode_next == M_IDLONG) ? sbt_pkg::K_IDENT
                                                    : sbt_pkg::word_kind(wbuf_next, wlen_next);
        bun.t2.token_start = 16'(tbeg_next);
        bun.t2.token_length = 16'(pinc - tbeg_next);
      end else if (mode_next == M_NUMBER) begin
        bun.t2.token_kind = sbt_pkg::K_INT;
        bun.t2.token_start = 16'(tbeg_next);
        bun.t2.token_length = 16'(pinc - tbeg_next);
      end else if (mode_next == M_STRING || mode_next == M_STRESC) begin
        bun.t2.token_kind = sbt_pkg::K_STRING;
        bun.t2.token_start = 16'(tbeg_next);
        bun.t2.token_length = 16'(pinc - tbeg_next);
      end else bun.t2.token_line = 16'hffff; // marker: no flushed token
      if (bun.t2.token_line == 16'hffff && bun.t2.token_kind == sbt_pkg::K_EOF
          && bun.t2.token_length == 16'd0 && !(pend_next != OP_NONE)) begin
        bun.t2.token_line = 16'(line_next);
        bun.t2.run_last = 1'b0;
      end else begin
        bun.t2.run_last = 1'b1; // flag: flushed token present
      end
      // shift flush token and end of file into place
      if (bun.t2.run_last) begin
        if (bun.count == 2'd0) bun.t0 = bun.t2;
        else if (bun.count == 2'd1) bun.t1 = bun.t2;
        bun.count = bun.count + 2'd1;
      end
      bun.t2 = '0;
      bun.t2.token_kind = sbt_pkg::K_EOF;
      bun.t2.token_start = 16'(pinc);
      bun.t2.token_line = 16'(line_next);
      if (bun.count == 2'd0) bun.t0 = bun.t2;
      else if (bun.count == 2'd1) bun.t1 = bun.t2;
      bun.count = bun.count + 2'd1;
      mode_next = M_IDLE; pend_next = OP_NONE; pos_next = '0; tbeg_next = '0;
      line_next = LINE_WIDTH'(1); wbuf_next = '0; wlen_next = 3'd0;
    end
    bun.t0.run_last = bun.count == 2'd1;
    bun.t1.run_last = bun.count == 2'd2;
    bun.t2.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; pend <= OP_NONE; pos <= '0; tbeg <= '0;
      line <= LINE_WIDTH'(1); wbuf <= '0; wlen <= 3'd0;
    end else if (take) begin
      mode <= mode_next; pend <= pend_next; pos <= pos_next; tbeg <= tbeg_next;
      line <= line_next; wbuf <= wbuf_next; wlen <= wlen_next;
    end
  end

  assign b_valid = in_valid && bun.count != 2'd0;
  assign b_data = bun;
endmodule

// ===== rtl/sbt_back.sv =====
// queue of token bundles and serializer onto the result channel
`timescale 1ns / 1ps
`include "source_byte_tokenizer_defines.svh"
module sbt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              b_valid,
  output logic              b_ready,
  input  sbt_pkg::bundle_t  b_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sbt_pkg::out_item_t out_data
);
  localparam int DEPTH = 4;
  sbt_pkg::bundle_t q [DEPTH];
  logic [1:0] wp, rp;
  logic [2:0] fill;
  logic [1:0] sub;
  logic push, pop_tok, pop_bun;
  sbt_pkg::bundle_t head;

  assign head = q[rp];
  assign b_ready = fill != 3'(DEPTH);
  assign push = b_valid && b_ready;
  assign out_valid = fill != 3'd0;
  assign pop_tok = out_valid && !out_stall;
  assign pop_bun = pop_tok && (sub + 2'd1 == head.count);

  always_comb begin
    unique case (sub)
      2'd0: out_data = head.t0;
      2'd1: out_data = head.t1;
      default: out_data = head.t2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= b_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0; sub <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop_bun) begin
        rp <= rp + 2'd1; sub <= '0;
      end else if (pop_tok) sub <= sub + 2'd1;
      fill <= fill + 3'(push) - 3'(pop_bun);
    end
  end

  `SBT_ASSERT(a_fill_bound, clk, rst, fill <= 3'(DEPTH))
  `SBT_ASSERT(a_sub_bound, clk, rst, out_valid |-> sub < head.count)
  `SBT_ASSERT(a_last_flag, clk, rst, pop_bun |-> out_data.run_last)
  `SBT_ASSERT_NR(a_reset_empty, clk, rst |=> fill == 3'd0)
endmodule

// ===== rtl/source_byte_tokenizer.sv =====
// top level of the source byte tokenizer
//  channel | direction | payload
//  in      | input     | sbt_pkg::in_item_t (ch, final_byte)
//  out     | output    | sbt_pkg::out_item_t (kind, start, length, line, run_last)
// one byte is taken per cycle while the queue has room; the front scanner updates its mode register on each taken byte
// each byte yields up to three tokens, sent out one per cycle while out_stall is low, from a four-bundle queue
// a burst of multi-token bytes stalls input once the queue fills
// rst is synchronous and returns the scanner to offset 0, line 1
`timescale 1ns / 1ps
module source_byte_tokenizer #(
  parameter int POSITION_WIDTH = 16,
  parameter int LINE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sbt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sbt_pkg::out_item_t out_data
);
  logic b_valid, b_ready;
  sbt_pkg::bundle_t b_data;

  sbt_front #(.POSITION_WIDTH(POSITION_WIDTH), .LINE_WIDTH(LINE_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .b_valid, .b_ready, .b_data
  );
  sbt_back u_back (
    .clk, .rst, .b_valid, .b_ready, .b_data, .out_valid, .out_stall, .out_data
  );
endmodule

// ===== bench/source_byte_tokenizer_tb.sv =====
// self-checking testbench for the source byte tokenizer
`timescale 1ns / 1ps
module source_byte_tokenizer_tb;

  typedef enum logic [3:0] {
    SM_IDLE, SM_IDENT, SM_IDLONG, SM_NUMBER, SM_STRING, SM_STRESC,
    SM_LINECOM, SM_BLOCK, SM_BLOCKSTAR
  } scan_mode_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_SLASH, OP_EQ, OP_BANG, OP_LT, OP_GT, OP_AMP, OP_BAR
  } pend_op_e;

  localparam logic [5:0] K_NONE = 6'd63;  // table row with no typed-in token
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BYTES = 225;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sbt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sbt_pkg::out_item_t out_data;

  always #6 clk = ~clk;

  source_byte_tokenizer DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  scan_mode_e mode;
  pend_op_e pend;
  logic [15:0] pos, tok_begin, line_no;
  logic [55:0] word;
  logic [2:0] word_len;

  sbt_pkg::out_item_t token_queue[$];
  sbt_pkg::out_item_t byte_tokens[$];
  int errors = 0;
  int tokens_seen = 0;
  int bytes_sent = 0;
  int cycles = 0;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] keyword_of(logic [55:0] w, logic [2:0] n);
    logic [5:0] k;
    string s;
    k = sbt_pkg::K_IDENT;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(w[8*i +: 8])};
    case (s)
      "int": k = sbt_pkg::K_KW_INT;
      "bool": k = sbt_pkg::K_KW_BOOL;
      "string": k = sbt_pkg::K_KW_STRING;
      "func": k = sbt_pkg::K_KW_FUNC;
      "for": k = sbt_pkg::K_KW_FOR;
      "to": k = sbt_pkg::K_KW_TO;
      "while": k = sbt_pkg::K_KW_WHILE;
      "if": k = sbt_pkg::K_KW_IF;
      "else": k = sbt_pkg::K_KW_ELSE;
      "return": k = sbt_pkg::K_KW_RETURN;
      "print": k = sbt_pkg::K_KW_PRINT;
      "input": k = sbt_pkg::K_KW_INPUT;
      "newline": k = sbt_pkg::K_KW_NEWLINE;
      "pattern": k = sbt_pkg::K_KW_PATTERN;
      "true", "false": k = sbt_pkg::K_BOOL;
      default: k = sbt_pkg::K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_alone(pend_op_e op);
    case (op)
      OP_SLASH: return sbt_pkg::K_SLASH;
      OP_EQ: return sbt_pkg::K_ASSIGN;
      OP_BANG: return sbt_pkg::K_NOT;
      OP_LT: return sbt_pkg::K_LT;
      OP_GT: return sbt_pkg::K_GT;
      default: return sbt_pkg::K_UNKNOWN;
    endcase
  endfunction

  task automatic push_token(logic [5:0] k, logic [15:0] s, logic [15:0] n);
    sbt_pkg::out_item_t t;
    t.token_kind = k;
    t.token_start = s;
    t.token_length = n;
    t.token_line = line_no;
    t.run_last = 1'b0;
    byte_tokens.insert(byte_tokens.size(), t);
  endtask

  task automatic bump_line();
    if (line_no != 16'hFFFF) line_no++;
  endtask

  task automatic reset_scanner();
    mode = SM_IDLE;
    pend = OP_NONE;
    pos = '0;
    tok_begin = '0;
    line_no = 16'd1;
    word = '0;
    word_len = '0;
  endtask

  function automatic logic [15:0] pos_next(logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  // returns 1 when the running token swallowed the byte
  task automatic continue_token(input logic [7:0] c, input logic [15:0] p, output bit used);
    pend_op_e op;
    logic [7:0] second;
    used = 1'b1;
    if (pend != OP_NONE) begin
      op = pend;
      pend = OP_NONE;
      second = (op == OP_AMP) ? "&" : (op == OP_BAR) ? "|" : "=";
      if (op == OP_SLASH && c == "/") mode = SM_LINECOM;
      else if (op == OP_SLASH && c == "*") mode = SM_BLOCK;
      else if (op != OP_SLASH && c == second) begin
        case (op)
          OP_EQ: push_token(sbt_pkg::K_EQ, tok_begin, 16'd2);
          OP_BANG: push_token(sbt_pkg::K_NE, tok_begin, 16'd2);
          OP_LT: push_token(sbt_pkg::K_LE, tok_begin, 16'd2);
          OP_GT: push_token(sbt_pkg::K_GE, tok_begin, 16'd2);
          OP_AMP: push_token(sbt_pkg::K_ANDAND, tok_begin, 16'd2);
          default: push_token(sbt_pkg::K_OROR, tok_begin, 16'd2);
        endcase
      end else begin
        push_token(op_alone(op), tok_begin, 16'd1);
        used = 1'b0;
      end
      return;
    end
    case (mode)
      SM_IDENT, SM_IDLONG: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (mode == SM_IDENT && word_len < 3'd7) begin
            word[8*word_len +: 8] = c;
            word_len++;
          end else mode = SM_IDLONG;
        end else begin
          push_token(mode == SM_IDLONG ? sbt_pkg::K_IDENT : keyword_of(word, word_len),
                     tok_begin, p - tok_begin);
          mode = SM_IDLE;
          used = 1'b0;
        end
      end
      SM_NUMBER: begin
        if (!is_digit(c)) begin
          push_token(sbt_pkg::K_INT, tok_begin, p - tok_begin);
          mode = SM_IDLE;
          used = 1'b0;
        end
      end
      SM_STRING: begin
        if (c == "\\") mode = SM_STRESC;
        else if (c == "\"") begin
          push_token(sbt_pkg::K_STRING, tok_begin, p - tok_begin);
          mode = SM_IDLE;
        end
      end
      SM_STRESC: mode = SM_STRING;
      SM_LINECOM: begin
        if (c == "\n") begin
          mode = SM_IDLE;
          used = 1'b0;
        end
      end
      SM_BLOCK: begin
        if (c == "*") mode = SM_BLOCKSTAR;
        else if (c == "\n") bump_line();
      end
      SM_BLOCKSTAR: begin
        if (c == "/") mode = SM_IDLE;
        else if (c != "*") begin
          mode = SM_BLOCK;
          if (c == "\n") bump_line();
        end
      end
      default: begin
        mode = SM_IDLE;
        used = 1'b0;
      end
    endcase
  endtask

  task automatic fresh_byte(logic [7:0] c, logic [15:0] p);
    case (c)
      " ", "\t", "\r": ;
      "\n": bump_line();
      "\"": begin
        mode = SM_STRING;
        tok_begin = pos_next(p);
      end
      "/": begin pend = OP_SLASH; tok_begin = p; end
      "=": begin pend = OP_EQ; tok_begin = p; end
      "!": begin pend = OP_BANG; tok_begin = p; end
      "<": begin pend = OP_LT; tok_begin = p; end
      ">": begin pend = OP_GT; tok_begin = p; end
      "&": begin pend = OP_AMP; tok_begin = p; end
      "|": begin pend = OP_BAR; tok_begin = p; end
      "+": push_token(sbt_pkg::K_PLUS, p, 16'd1);
      "-": push_token(sbt_pkg::K_MINUS, p, 16'd1);
      "*": push_token(sbt_pkg::K_STAR, p, 16'd1);
      "%": push_token(sbt_pkg::K_PCT, p, 16'd1);
      "(": push_token(sbt_pkg::K_LPAREN, p, 16'd1);
      ")": push_token(sbt_pkg::K_RPAREN, p, 16'd1);
      "{": push_token(sbt_pkg::K_LBRACE, p, 16'd1);
      "}": push_token(sbt_pkg::K_RBRACE, p, 16'd1);
      ",": push_token(sbt_pkg::K_COMMA, p, 16'd1);
      ";": push_token(sbt_pkg::K_SEMI, p, 16'd1);
      default: begin
        if (is_alpha(c)) begin
          mode = SM_IDENT;
          tok_begin = p;
          word = {48'd0, c};
          word_len = 3'd1;
        end else if (is_digit(c)) begin
          mode = SM_NUMBER;
          tok_begin = p;
        end else push_token(sbt_pkg::K_UNKNOWN, p, 16'd1);
      end
    endcase
  endtask

  // predicts the tokens for one byte and queues them
  task automatic predict_tokens(sbt_pkg::in_item_t item);
    bit used;
    logic [15:0] p;
    p = pos;
    byte_tokens.delete();
    continue_token(item.ch, p, used);
    if (!used) fresh_byte(item.ch, p);
    pos = pos_next(p);
    if (item.final_byte) begin
      if (pend != OP_NONE) push_token(op_alone(pend), tok_begin, 16'd1);
      if (mode == SM_IDENT) push_token(keyword_of(word, word_len), tok_begin, pos - tok_begin);
      else if (mode == SM_IDLONG) push_token(sbt_pkg::K_IDENT, tok_begin, pos - tok_begin);
      else if (mode == SM_NUMBER) push_token(sbt_pkg::K_INT, tok_begin, pos - tok_begin);
      else if (mode == SM_STRING || mode == SM_STRESC)
        push_token(sbt_pkg::K_STRING, tok_begin, pos - tok_begin);
      push_token(sbt_pkg::K_EOF, pos, 16'd0);
      reset_scanner();
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
    foreach (byte_tokens[i]) token_queue.insert(token_queue.size(), byte_tokens[i]);
  endtask

  // directed table: byte, final flag, and the single typed-in token kind where obvious
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic [5:0] kind;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(logic [7:0] ch, logic fin, logic [5:0] kind);
    dir_row_t row;
    row.ch = ch;
    row.fin = fin;
    row.kind = kind;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_text(string s, logic [5:0] first_kind = K_NONE);
    for (int i = 0; i < s.len(); i++)
      add_row(s[i], i == s.len() - 1, (i == 0) ? first_kind : K_NONE);
  endtask

  // feeds one transaction, honoring backpressure
  task automatic send_byte(sbt_pkg::in_item_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(item);
    bytes_sent++;
  endtask

  int burst_left = 0;

  task automatic send_paced(sbt_pkg::in_item_t item);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    send_byte(item);
  endtask

  const string snippets[] = '{
    "int x = 42;\n", "bool b = true;", "string s = \"a\\\"b\";", "func f(a, b) {",
    "for i = 0 to 9 {", "while (a <= b) { return a != b; }", "if a == b else c",
    "print(input);", "newline pattern false", "a && b || c", "x >= 1 % 3 - 2 * 7",
    "// note\n", "/* multi\nline **/", "longidentifier1 a1_b", "!x < y > z",
    "\"line\nbreak\"", "0123456789", "ZZ_top9"
  };

  // mostly well-formed source with random glue, plus raw noise
  task automatic send_random_source();
    int pieces;
    string s;
    sbt_pkg::in_item_t item;
    pieces = $urandom_range(1, 4);
    for (int k = 0; k < pieces; k++) begin
      if ($urandom_range(0, 4) != 0) s = snippets[$urandom_range(0, snippets.size() - 1)];
      else begin
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(0, 255)))};
      end
      if (s.len() == 0) s = " ";
      for (int i = 0; i < s.len(); i++) begin
        item.ch = s[i];
        item.final_byte = (k == pieces - 1) && (i == s.len() - 1);
        send_paced(item);
      end
      item.ch = ($urandom_range(0, 1) != 0) ? 8'h20 : 8'h0A;
      item.final_byte = 1'b0;
      if (k != pieces - 1) send_paced(item);
    end
  endtask

  // receiver stall pattern: alternating quiet and choppy stretches
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if ((cycles / 200) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    sbt_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      tokens_seen++;
      if (token_queue.size() == 0) begin
        $error("unexpected token kind %0d", out_data.token_kind);
        errors++;
      end else begin
        want = token_queue.pop_front();
        if (out_data.token_kind !== want.token_kind) begin
          $error("token_kind expected %0d actual %0d", want.token_kind, out_data.token_kind);
          errors++;
        end
        if (out_data.token_start !== want.token_start) begin
          $error("token_start expected %0d actual %0d", want.token_start, out_data.token_start);
          errors++;
        end
        if (out_data.token_length !== want.token_length) begin
          $error("token_length expected %0d actual %0d", want.token_length,
                 out_data.token_length);
          errors++;
        end
        if (out_data.token_line !== want.token_line) begin
          $error("token_line expected %0d actual %0d", want.token_line, out_data.token_line);
          errors++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last expected %0d actual %0d", want.run_last, out_data.run_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    sbt_pkg::in_item_t item;
    reset_scanner();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: lone final bytes give a typed-in first token
    add_text("+", sbt_pkg::K_PLUS);
    add_text("&", sbt_pkg::K_UNKNOWN);
    add_row(8'hFF, 1'b1, sbt_pkg::K_UNKNOWN);
    add_row(8'h00, 1'b1, sbt_pkg::K_UNKNOWN);
    add_text(";", sbt_pkg::K_SEMI);
    add_text("|", sbt_pkg::K_UNKNOWN);
    add_text("\n", sbt_pkg::K_EOF);
    foreach (dir_rows[i]) begin
      item.ch = dir_rows[i].ch;
      item.final_byte = dir_rows[i].fin;
      send_byte(item);
      if (dir_rows[i].kind != K_NONE && token_queue.size() > 0 &&
          token_queue[token_queue.size() - byte_tokens.size()].token_kind != dir_rows[i].kind) begin
        $error("token_kind expected %0d from table row %0d", dir_rows[i].kind, i);
        errors++;
      end
    end
    dir_rows.delete();
    // directed: unterminated comment and string, escapes and double slash
    add_text("/* open");
    add_text("\"ab\\");
    add_text("x// c\n=");
    add_text("if a==b{return 1;}");
    foreach (dir_rows[i]) begin
      item.ch = dir_rows[i].ch;
      item.final_byte = dir_rows[i].fin;
      send_paced(item);
    end

    // random sources until the byte budget is used
    while (bytes_sent < RANDOM_BYTES) send_random_source();
    in_valid <= 1'b0;

    while (token_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d source bytes and %0d tokens, with directed edge cases,",
             bytes_sent, tokens_seen);
    $display("random sources in bursts and stalls on both sides");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/sbt_pkg.sv
rtl/sbt_front.sv
rtl/sbt_back.sv
rtl/source_byte_tokenizer.sv
bench/source_byte_tokenizer_tb.sv
